[hw/rtl/gpr_pkg.sv]
// gpr_pkg: shared types and constants for the glyph pixel renderer.
// Used by gpr_addr_pipe, glyph_pixel_renderer and the bench; depends on nothing.
package gpr_pkg;

    // Store geometry
    localparam int FONT_BITS     = 65536;
    localparam int FONT_AW       = $clog2(FONT_BITS);
    localparam int PALETTE_SIZE  = 16;
    localparam int PAL_AW        = $clog2(PALETTE_SIZE);

    // Field widths
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 32;
    localparam int DIM_W    = 6;
    localparam int FLAGS_W  = 7;
    localparam int CODE_W   = 8;
    localparam int POS_W    = 5;
    localparam int CW_W     = CODE_W + DIM_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Attribute flag bit positions
    localparam int FL_HFLIP   = 0;
    localparam int FL_VFLIP   = 1;
    localparam int FL_RCW     = 2;
    localparam int FL_RCCW    = 3;
    localparam int FL_REVERSE = 4;
    localparam int FL_MASKED  = 5;
    localparam int FL_NODRAW  = 6;

    // RGB inversion mask, alpha kept
    localparam logic [COLOR_W-1:0] RGB_MASK = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        OP_PAL_WR  = 2'd0,
        OP_FONT_WR = 2'd1,
        OP_RENDER  = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG     = 3'd0,
        CFG_BG     = 3'd1,
        CFG_ATTR   = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } cfg_idx_t;

    // Beat handed from the address pipe to the memory stage
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] addr;   // font bit address or write index
        logic [COLOR_W-1:0] data;   // existing pixel or write data
    } item_t;

endpackage

[hw/rtl/gpr_addr_pipe.sv]
// gpr_addr_pipe: two-stage coordinate transform and font bit address pipe.
// Depends on gpr_pkg.
module gpr_addr_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              accept,
    input  logic [1:0]                        opcode,
    input  logic [gpr_pkg::CODE_W-1:0]        char_code,
    input  logic [gpr_pkg::POS_W-1:0]         glyph_col,
    input  logic [gpr_pkg::POS_W-1:0]         glyph_row,
    input  logic [gpr_pkg::COLOR_W-1:0]       existing_pixel,
    input  logic [gpr_pkg::COORD_W-1:0]       write_index,
    input  logic [gpr_pkg::COLOR_W-1:0]       write_data,
    input  logic [gpr_pkg::FLAGS_W-1:0]       flags,
    input  logic [gpr_pkg::DIM_W-1:0]         width,
    input  logic [gpr_pkg::DIM_W-1:0]         height,
    output logic                              item_valid,
    output gpr_pkg::item_t                    item
);

    logic [gpr_pkg::COORD_W-1:0] w16;
    logic [gpr_pkg::COORD_W-1:0] h16;
    logic [gpr_pkg::COORD_W-1:0] gx0, gy0, gx1, gy1, gx2, gy2, gx3, gy3;
    logic [gpr_pkg::COORD_W-1:0] t_cw, t_ccw;
    logic [gpr_pkg::CW_W-1:0]    cw;
    logic [gpr_pkg::CW_W+gpr_pkg::DIM_W-1:0]    base_full;
    logic [gpr_pkg::COORD_W+gpr_pkg::DIM_W-1:0] gyw_full;
    gpr_pkg::op_t                op_in;

    // stage A registers
    logic                        a_valid_reg;
    gpr_pkg::op_t                a_op_reg;
    logic [gpr_pkg::COORD_W-1:0] a_gx_reg, a_gy_reg, a_widx_reg;
    logic [gpr_pkg::CW_W-1:0]    a_cw_reg;
    logic [gpr_pkg::COLOR_W-1:0] a_data_reg;

    // stage B registers
    logic                        b_valid_reg;
    gpr_pkg::op_t                b_op_reg;
    logic [gpr_pkg::COORD_W-1:0] b_gx_reg, b_base_reg, b_gyw_reg, b_widx_reg;
    logic [gpr_pkg::COLOR_W-1:0] b_data_reg;

    assign w16   = gpr_pkg::COORD_W'(width);
    assign h16   = gpr_pkg::COORD_W'(height);
    assign op_in = gpr_pkg::op_t'(opcode);

    // mirror, then rotate cw, then rotate ccw (all mod 2^16)
    always_comb
    begin
        gx0   = gpr_pkg::COORD_W'(glyph_col);
        gy0   = gpr_pkg::COORD_W'(glyph_row);
        gx1   = flags[gpr_pkg::FL_HFLIP] ? (w16 - 16'd1 - gx0) : gx0;
        gy1   = flags[gpr_pkg::FL_VFLIP] ? (h16 - 16'd1 - gy0) : gy0;
        t_cw  = w16 - 16'd1 - gx1;
        gx2   = flags[gpr_pkg::FL_RCW] ? gy1 : gx1;
        gy2   = flags[gpr_pkg::FL_RCW] ? t_cw : gy1;
        t_ccw = h16 - 16'd1 - gy2;
        gy3   = flags[gpr_pkg::FL_RCCW] ? gx2 : gy2;
        gx3   = flags[gpr_pkg::FL_RCCW] ? t_ccw : gx2;
        cw    = gpr_pkg::CW_W'(char_code) * gpr_pkg::CW_W'(width);
    end

    // second multiplies: glyph base and row offset
    assign base_full = a_cw_reg * height;
    assign gyw_full  = a_gy_reg * width;

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_op_reg   <= op_in;
            a_gx_reg   <= gx3;
            a_gy_reg   <= gy3;
            a_cw_reg   <= cw;
            a_widx_reg <= write_index;
            a_data_reg <= (op_in == gpr_pkg::OP_RENDER) ? existing_pixel : write_data;

            b_op_reg   <= a_op_reg;
            b_gx_reg   <= a_gx_reg;
            b_base_reg <= base_full[gpr_pkg::COORD_W-1:0];
            b_gyw_reg  <= gyw_full[gpr_pkg::COORD_W-1:0];
            b_widx_reg <= a_widx_reg;
            b_data_reg <= a_data_reg;
        end
    end

    // final address sum; writes carry their own index
    always_comb
    begin
        item_valid = b_valid_reg;
        item.op    = b_op_reg;
        item.data  = b_data_reg;
        if (b_op_reg == gpr_pkg::OP_RENDER)
            item.addr = b_base_reg + b_gx_reg + b_gyw_reg;
        else
            item.addr = b_widx_reg;
    end

endmodule

[hw/rtl/glyph_pixel_renderer.sv]
// glyph_pixel_renderer: top level, palette and font memories, color select.
// Depends on gpr_pkg and gpr_addr_pipe.
//
// One input beat is taken per clock while in_ready is high. A render beat
// (opcode 2) passes stages A, B, memory and output register; palette and
// font write beats (opcodes 0 and 1) and the unused opcode yield nothing. The
// rate is set by the single access port of the font memory, which serves one
// read or one write each cycle; beats update and read the memories in the same
// pipeline stage, so a write is seen by every later render beat. A two-deep
// output register (output plus skid entry) lets the pipeline keep going
// while one result waits; input ready drops only when both are full.
// Configuration writes are always accepted and take effect next cycle.
module glyph_pixel_renderer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic [gpr_pkg::CODE_W-1:0]         char_code,
    input  logic [gpr_pkg::POS_W-1:0]          glyph_col,
    input  logic [gpr_pkg::POS_W-1:0]          glyph_row,
    input  logic [gpr_pkg::COLOR_W-1:0]        existing_pixel,
    input  logic [gpr_pkg::COORD_W-1:0]        write_index,
    input  logic [gpr_pkg::COLOR_W-1:0]        write_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gpr_pkg::COLOR_W-1:0]        pixel_color,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [gpr_pkg::PAL_AW-1:0]  fg_index_reg;
    logic [gpr_pkg::PAL_AW-1:0]  bg_index_reg;
    logic [gpr_pkg::FLAGS_W-1:0] attr_flags_reg;
    logic [gpr_pkg::DIM_W-1:0]   glyph_width_reg;
    logic [gpr_pkg::DIM_W-1:0]   glyph_height_reg;

    // memories
    logic [gpr_pkg::COLOR_W-1:0] palette_mem [gpr_pkg::PALETTE_SIZE];
    logic                        font_mem    [gpr_pkg::FONT_BITS];

    logic                        adv;
    logic                        accept;
    logic                        item_valid;
    gpr_pkg::item_t              item;

    // memory stage
    logic                        m_valid_reg;
    gpr_pkg::op_t                m_op_reg;
    logic [gpr_pkg::COLOR_W-1:0] m_data_reg;
    logic [gpr_pkg::COLOR_W-1:0] fg_color_reg;
    logic [gpr_pkg::COLOR_W-1:0] bg_color_reg;
    logic                        font_bit_reg;

    logic                        res_valid;
    logic [gpr_pkg::COLOR_W-1:0] res_color;

    // output and skid
    logic                        out_valid_reg;
    logic [gpr_pkg::COLOR_W-1:0] out_color_reg;
    logic                        skid_valid_reg;
    logic [gpr_pkg::COLOR_W-1:0] skid_color_reg;
    logic                        out_free;

    assign adv       = !skid_valid_reg;
    assign in_ready  = adv;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_index_reg     <= 4'd7;
            bg_index_reg     <= 4'd0;
            attr_flags_reg   <= 7'd0;
            glyph_width_reg  <= 6'd8;
            glyph_height_reg <= 6'd16;
        end
        else if (cfg_valid)
        begin
            case (gpr_pkg::cfg_idx_t'(cfg_index))
                gpr_pkg::CFG_FG:     fg_index_reg     <= cfg_data[gpr_pkg::PAL_AW-1:0];
                gpr_pkg::CFG_BG:     bg_index_reg     <= cfg_data[gpr_pkg::PAL_AW-1:0];
                gpr_pkg::CFG_ATTR:   attr_flags_reg   <= cfg_data;
                gpr_pkg::CFG_WIDTH:  glyph_width_reg  <= cfg_data[gpr_pkg::DIM_W-1:0];
                gpr_pkg::CFG_HEIGHT: glyph_height_reg <= cfg_data[gpr_pkg::DIM_W-1:0];
                default:             ;
            endcase
        end
    end

    // coordinate transform and address pipe
    gpr_addr_pipe u_addr (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .accept         (accept),
        .opcode         (opcode),
        .char_code      (char_code),
        .glyph_col      (glyph_col),
        .glyph_row      (glyph_row),
        .existing_pixel (existing_pixel),
        .write_index    (write_index),
        .write_data     (write_data),
        .flags          (attr_flags_reg),
        .width          (glyph_width_reg),
        .height         (glyph_height_reg),
        .item_valid     (item_valid),
        .item           (item)
    );

    // palette memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (item_valid && item.op == gpr_pkg::OP_PAL_WR)
                palette_mem[item.addr[gpr_pkg::PAL_AW-1:0]] <= item.data;
            fg_color_reg <= palette_mem[fg_index_reg];
            bg_color_reg <= palette_mem[bg_index_reg];
        end
    end

    // font memory: single port, write or registered read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (item_valid && item.op == gpr_pkg::OP_FONT_WR)
                font_mem[item.addr[gpr_pkg::FONT_AW-1:0]] <= (item.data != '0);
            else
                font_bit_reg <= font_mem[item.addr[gpr_pkg::FONT_AW-1:0]];
        end
    end

    // memory stage control and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_op_reg   <= item.op;
            m_data_reg <= item.data;
        end
    end

    // color select
    always_comb
    begin
        res_valid = adv && m_valid_reg && (m_op_reg == gpr_pkg::OP_RENDER);
        if (attr_flags_reg[gpr_pkg::FL_NODRAW])
            res_color = bg_color_reg;
        else if (font_bit_reg)
            res_color = attr_flags_reg[gpr_pkg::FL_REVERSE]
                      ? (m_data_reg ^ gpr_pkg::RGB_MASK) : fg_color_reg;
        else if (attr_flags_reg[gpr_pkg::FL_MASKED] && bg_index_reg == '0)
            res_color = m_data_reg;
        else
            res_color = bg_color_reg;
    end

    // output register with skid entry
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res_valid;
        end
        else if (res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_color_reg <= skid_color_reg;
            else if (res_valid)
                out_color_reg <= res_color;
        end
        else if (res_valid)
            skid_color_reg <= res_color;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;

endmodule

[bench/glyph_pixel_renderer_tb.sv]
// Self-checking bench for glyph_pixel_renderer: random and corner-case beats
// checked against a cycle-free color predictor. Depends on gpr_pkg and the RTL.
`timescale 1ns / 100ps

module glyph_pixel_renderer_tb;
    import gpr_pkg::*;

    localparam int N_PHASES     = 12;
    localparam int RAND_PER_PH  = 64;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;    // pipe is four deep plus a skid entry

    typedef struct {
        op_t                op;
        logic [CODE_W-1:0]  code;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [COLOR_W-1:0] exist;
        logic [COORD_W-1:0] widx;
        logic [COLOR_W-1:0] wdata;
    } beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             opcode = OP_RSVD;
    logic [CODE_W-1:0]      char_code = '0;
    logic [POS_W-1:0]       glyph_col = '0;
    logic [POS_W-1:0]       glyph_row = '0;
    logic [COLOR_W-1:0]     existing_pixel = '0;
    logic [COORD_W-1:0]     write_index = '0;
    logic [COLOR_W-1:0]     write_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [COLOR_W-1:0]     pixel_color;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow of the block: registers, palette and font bits
    logic [3:0]             sh_fg = 4'd7;
    logic [3:0]             sh_bg = 4'd0;
    logic [FLAGS_W-1:0]     sh_attr = '0;
    logic [DIM_W-1:0]       sh_w = 6'd8;
    logic [DIM_W-1:0]       sh_h = 6'd16;
    logic [COLOR_W-1:0]     palette_sh [PALETTE_SIZE];
    bit                     font_sh [FONT_BITS];
    bit                     font_loaded [FONT_BITS];   // stimulus side only

    beat_t                  stim_q [$];
    logic [COLOR_W-1:0]     pixel_expect_q [$];
    beat_t                  cur_beat;
    logic [COLOR_W-1:0]     want;
    int                     beats_left = 0;
    int                     send_gap = 0;
    int                     recv_gap = 0;
    int                     hold_left = 0;
    bit                     hold_req = 1'b0;
    bit                     gaps_on = 1'b1;
    int                     err_cnt = 0;
    int                     stall_cycles = 0;

    glyph_pixel_renderer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .char_code      (char_code),
        .glyph_col      (glyph_col),
        .glyph_row      (glyph_row),
        .existing_pixel (existing_pixel),
        .write_index    (write_index),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_color    (pixel_color),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Font bit address after mirror and rotate, all mod 2^16
    function automatic logic [COORD_W-1:0] glyph_bit_addr(input logic [CODE_W-1:0] code,
                                                          input logic [POS_W-1:0] col,
                                                          input logic [POS_W-1:0] row);
        logic [COORD_W-1:0] gx, gy, t, w, h;
        w  = 16'(sh_w);
        h  = 16'(sh_h);
        gx = 16'(col);
        gy = 16'(row);
        if (sh_attr[FL_HFLIP])
            gx = w - 16'd1 - gx;
        if (sh_attr[FL_VFLIP])
            gy = h - 16'd1 - gy;
        if (sh_attr[FL_RCW])
        begin
            t  = w - 16'd1 - gx;
            gx = gy;
            gy = t;
        end
        if (sh_attr[FL_RCCW])
        begin
            t  = h - 16'd1 - gy;
            gy = gx;
            gx = t;
        end
        return 16'(code) * w * h + gx + gy * w;
    endfunction

    // Expected color of one render beat
    function automatic logic [COLOR_W-1:0] render_color(input beat_t b);
        logic [COLOR_W-1:0] bg_color;
        bg_color = palette_sh[sh_bg];
        if (sh_attr[FL_NODRAW])
            return bg_color;
        if (font_sh[glyph_bit_addr(b.code, b.col, b.row)])
            return sh_attr[FL_REVERSE] ? (b.exist ^ RGB_MASK) : palette_sh[sh_fg];
        if (sh_attr[FL_MASKED] && sh_bg == 4'd0)
            return b.exist;
        return bg_color;
    endfunction

    function automatic logic [COLOR_W-1:0] font_word(input bit set);
        return set ? ($urandom | (32'd1 << $urandom_range(0, 31))) : '0;
    endfunction

    task automatic queue_beat(input op_t op, input logic [CODE_W-1:0] code,
                              input logic [POS_W-1:0] col, input logic [POS_W-1:0] row,
                              input logic [COLOR_W-1:0] exist,
                              input logic [COORD_W-1:0] widx,
                              input logic [COLOR_W-1:0] wdata);
        beat_t b;
        b = '{op, code, col, row, exist, widx, wdata};
        if (op == OP_FONT_WR)
            font_loaded[widx] = 1'b1;
        stim_q.push_back(b);
        beats_left++;
    endtask

    // Render beat; the font bit it reads is loaded first when needed.
    // bit_sel 0 or 1 forces the bit, anything else loads a random one only if none is loaded yet.
    task automatic queue_render(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] col,
                                input logic [POS_W-1:0] row, input logic [COLOR_W-1:0] exist,
                                input int bit_sel);
        logic [COORD_W-1:0] a;
        a = glyph_bit_addr(code, col, row);
        if (bit_sel == 0 || bit_sel == 1)
            queue_beat(OP_FONT_WR, CODE_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       $urandom, a, font_word(bit_sel == 1));
        else if (!font_loaded[a])
            queue_beat(OP_FONT_WR, CODE_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       $urandom, a, font_word(1'($urandom_range(0, 1))));
        queue_beat(OP_RENDER, code, col, row, exist, COORD_W'($urandom), $urandom);
    endtask

    // Register write; valid is lowered before the task returns, so it is never re-raised in the same step
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_FG:     sh_fg   = val[3:0];
            CFG_BG:     sh_bg   = val[3:0];
            CFG_ATTR:   sh_attr = val;
            CFG_WIDTH:  sh_w    = val[DIM_W-1:0];
            CFG_HEIGHT: sh_h    = val[DIM_W-1:0];
            default:    ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic note_mismatch(input bit have_exp, input logic [COLOR_W-1:0] exp_color,
                                 input logic [COLOR_W-1:0] got_color);
        err_cnt++;
        if (err_cnt <= 10)
        begin
            if (have_exp)
                $display("pixel_color mismatch: expected %h, got %h", exp_color, got_color);
            else
                $display("pixel_color %h with no beat outstanding", got_color);
        end
    endtask

    // Input driver: predicts on accept, then offers the next queued beat
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                case (cur_beat.op)
                    OP_PAL_WR:  palette_sh[cur_beat.widx[PAL_AW-1:0]] = cur_beat.wdata;
                    OP_FONT_WR: font_sh[cur_beat.widx] = (cur_beat.wdata != '0);
                    OP_RENDER:  pixel_expect_q.push_back(render_color(cur_beat));
                    default:    ;
                endcase
                beats_left--;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() > 0)
                begin
                    cur_beat       = stim_q.pop_front();
                    opcode         <= cur_beat.op;
                    char_code      <= cur_beat.code;
                    glyph_col      <= cur_beat.col;
                    glyph_row      <= cur_beat.row;
                    existing_pixel <= cur_beat.exist;
                    write_index    <= cur_beat.widx;
                    write_data     <= cur_beat.wdata;
                    in_valid       <= 1'b1;
                    send_gap       = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_expect_q.size() == 0)
                    note_mismatch(1'b0, '0, pixel_color);
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (pixel_color !== want)
                        note_mismatch(1'b1, want, pixel_color);
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  = pick_gap();
            end
        end
    end

    // Watchdog: too long with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("glyph_pixel_renderer_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Phases: registers set while idle, then directed and random beats
    initial
    begin
        logic [CFG_DATA_W-1:0] fixed_cfg [1:5][5];
        logic [CODE_W-1:0]     code;
        logic [POS_W-1:0]      col, row;
        int                    r;

        //              fg     bg     attr   width  height
        fixed_cfg[1] = '{7'd15, 7'd0,  7'h21, 7'd1,  7'd1};
        fixed_cfg[2] = '{7'd0,  7'd15, 7'h16, 7'd32, 7'd32};
        fixed_cfg[3] = '{7'h7F, 7'd0,  7'h7F, 7'd0,  7'd63};
        fixed_cfg[4] = '{7'd5,  7'd0,  7'h3C, 7'd63, 7'd0};
        fixed_cfg[5] = '{7'd0,  7'h70, 7'h2B, 7'h7F, 7'd1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            gaps_on = (ph != 8);

            // Reset values are used as they stand in the first phase
            if (ph >= 1 && ph <= 5)
            begin
                write_reg(CFG_FG,     fixed_cfg[ph][0]);
                write_reg(CFG_BG,     fixed_cfg[ph][1]);
                write_reg(CFG_ATTR,   fixed_cfg[ph][2]);
                write_reg(CFG_WIDTH,  fixed_cfg[ph][3]);
                write_reg(CFG_HEIGHT, fixed_cfg[ph][4]);
            end
            else if (ph > 5)
            begin
                write_reg(CFG_FG,   7'($urandom_range(0, 127)));
                write_reg(CFG_BG,   ($urandom_range(0, 1) == 0) ? 7'd0
                                                                : 7'($urandom_range(0, 127)));
                write_reg(CFG_ATTR, 7'($urandom_range(0, 127)));
                write_reg(CFG_WIDTH,  ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 32))
                                                                  : 7'($urandom_range(0, 127)));
                write_reg(CFG_HEIGHT, ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 32))
                                                                  : 7'($urandom_range(0, 127)));
            end

            // Load every palette entry, top index bit set, plus an unused opcode
            if (ph == 0)
            begin
                for (int i = 0; i < PALETTE_SIZE; i++)
                    queue_beat(OP_PAL_WR, CODE_W'($urandom), POS_W'($urandom),
                               POS_W'($urandom), $urandom,
                               {12'($urandom) | 12'h800, 4'(i)},
                               (i == 0) ? 32'h0 : (i == PALETTE_SIZE - 1) ? 32'hFFFF_FFFF
                                                                          : $urandom);
                queue_beat(OP_RSVD, CODE_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                           $urandom, COORD_W'($urandom), $urandom);
            end

            // Corner pixels with the glyph bit forced both ways
            queue_render(8'd0,   5'd0,  5'd0,  32'h0000_0000, 1);
            queue_render(8'd255, 5'd31, 5'd31, 32'hFFFF_FFFF, 0);
            queue_render(8'd255, 5'd0,  5'd31, $urandom, 1);
            queue_render(8'd0,   5'd31, 5'd0,  $urandom, 0);

            for (int n = 0; n < RAND_PER_PH; n++)
            begin
                r    = $urandom_range(0, 99);
                code = CODE_W'($urandom);
                col  = POS_W'($urandom);
                row  = POS_W'($urandom);
                if (r < 55)
                    queue_render(code, col, row, $urandom, -1);
                else if (r < 75)
                    queue_beat(OP_FONT_WR, CODE_W'($urandom), POS_W'($urandom),
                               POS_W'($urandom), $urandom,
                               ($urandom_range(0, 1) == 0) ? glyph_bit_addr(code, col, row)
                                                           : 16'($urandom),
                               font_word(1'($urandom_range(0, 1))));
                else if (r < 92)
                    queue_beat(OP_PAL_WR, CODE_W'($urandom), POS_W'($urandom),
                               POS_W'($urandom), $urandom, COORD_W'($urandom), $urandom);
                else
                    queue_beat(OP_RSVD, CODE_W'($urandom), POS_W'($urandom),
                               POS_W'($urandom), $urandom, COORD_W'($urandom), $urandom);
            end

            // Long receiver hold-off while the sender keeps offering beats
            if (ph == 6)
                hold_req = 1'b1;

            // Idle: everything accepted, every pixel back, pipe drained
            while (beats_left != 0 || pixel_expect_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        if (err_cnt == 0)
            $display("glyph_pixel_renderer_tb: done, clean");
        else
            $display("glyph_pixel_renderer_tb: done, errors");
        $finish;
    end

endmodule

[glyph_pixel_renderer.f]
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_addr_pipe.sv
hw/rtl/glyph_pixel_renderer.sv
bench/glyph_pixel_renderer_tb.sv
